### rtl/srld_pkg.sv
// Shared types and constants for the stereo RMS level detector.
`default_nettype none

package srld_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned SQUARE_W   = 31;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned QUOT_W     = 33;
   localparam int unsigned ROOT_W     = 17;
   localparam int unsigned RAD_W      = 2 * ROOT_W;
   localparam int unsigned SREM_W     = 18;
   localparam int unsigned STEP_W     = 6;
   localparam int unsigned DIV_STEPS  = QUOT_W;
   localparam int unsigned ROOT_STEPS = ROOT_W;

   localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'd655;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'hFFFF;

   typedef struct packed {
      logic in_ready;
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic out_load;
   } srld_cmd_type;

   typedef struct packed {
      logic pipe_last;
      logic out_busy;
   } srld_stat_type;

endpackage

`default_nettype wire

### rtl/srld_ctrl.sv
// Sequencer for accumulation, division, square root and result hand-off.
`default_nettype none

module srld_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tlast,
   input  wire srld_pkg::srld_stat_type stat,
   output srld_pkg::srld_cmd_type      cmd
);
   import srld_pkg::*;

   typedef enum logic [2:0] {
      ACCUM,
      FLUSH,
      DIVIDE,
      ROOT_LOAD,
      ROOT,
      DELIVER
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ACCUM: begin
            if (req_tvalid && req_tlast) begin
               state_in = FLUSH;
            end
         end
         FLUSH: begin
            state_in = DIVIDE;
            step_in  = '0;
         end
         DIVIDE: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ROOT_LOAD;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ROOT_LOAD: begin
            state_in = ROOT;
            step_in  = '0;
         end
         ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = DELIVER;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         DELIVER: begin
            if (!stat.out_busy) begin
               state_in = ACCUM;
            end
         end
         default: begin
            state_in = ACCUM;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd.in_ready  = (state_ff == ACCUM);
      cmd.div_load  = (state_ff == FLUSH);
      cmd.div_step  = (state_ff == DIVIDE);
      cmd.root_load = (state_ff == ROOT_LOAD);
      cmd.root_step = (state_ff == ROOT);
      cmd.out_load  = (state_ff == DELIVER) && !stat.out_busy;
   end

   // The final frame of a packet must be in the square stage when its sums are handed over.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == FLUSH |-> stat.pipe_last)
      else $error("flush without the last frame in the square stage");

   // Accepting the last frame of a packet stops intake until the result is formed.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.in_ready && req_tvalid && req_tlast) |=> !cmd.in_ready)
      else $error("intake still open after last frame");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_load, cmd.div_step, cmd.root_load, cmd.root_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == DIVIDE |-> step_ff < STEP_W'(DIV_STEPS))
      else $error("division step count out of range");

endmodule

`default_nettype wire

### rtl/srld_datapath.sv
// Square-and-accumulate stage, shift-subtract divider, digit-by-digit root and output register.
`default_nettype none

module srld_datapath #(
   parameter int unsigned MAX_FRAMES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire srld_pkg::srld_cmd_type           cmd,
   output srld_pkg::srld_stat_type               stat,
   input  wire logic                             req_tvalid,
   input  wire logic [2*srld_pkg::SAMPLE_W-1:0]  req_tdata,
   input  wire logic                             req_tuser,
   input  wire logic                             req_tlast,
   input  wire logic                             csr_wen,
   input  wire logic [srld_pkg::LEVEL_W-1:0]     csr_wdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [srld_pkg::LEVEL_W-1:0]          rsp_tdata,
   output logic [1:0]                            rsp_tuser
);
   import srld_pkg::*;

   localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
   localparam int unsigned SW = CW + SQUARE_W;
   localparam int unsigned DW = SW + 1;

   logic                 accept;
   logic signed [SAMPLE_W-1:0]   left_s, right_s;
   logic signed [2*SAMPLE_W-1:0] left_sq, right_sq;

   logic                 p_valid_ff;
   logic                 p_last_ff, p_silent_ff;
   logic [SQUARE_W-1:0]  sq_l_ff, sq_r_ff;

   logic [SW-1:0]        sum_ff, sum_add, sum_new;
   logic [CW-1:0]        count_ff, count_new;
   logic                 ovf_ff, ovf_new, room;

   logic [CW-1:0]        rem_ff, rem_in, divisor_ff;
   logic [QUOT_W-1:0]    q_ff, q_in;
   logic [DW-1:0]        dividend;
   logic [CW:0]          trial, diff;
   logic                 ge;
   logic                 zero_ff, silent_ff, ovf_res_ff;

   logic [RAD_W-1:0]     v_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic [SREM_W-1:0]    srem_ff, srem_in;
   logic [SREM_W+1:0]    sx, st, sd;
   logic                 sge;

   logic [LEVEL_W-1:0]   thresh_ff, level, level_ff;
   logic                 playing_ff, ovf_out_ff, rsp_valid_ff;

   assign accept   = req_tvalid & cmd.in_ready;
   assign left_s   = req_tdata[SAMPLE_W-1:0];
   assign right_s  = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign left_sq  = left_s * left_s;
   assign right_sq = right_s * right_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
      if (accept) begin
         sq_l_ff     <= left_sq[SQUARE_W-1:0];
         sq_r_ff     <= right_sq[SQUARE_W-1:0];
         p_last_ff   <= req_tlast;
         p_silent_ff <= req_tuser;
      end
   end

   always_comb begin
      room      = count_ff < CW'(MAX_FRAMES);
      sum_add   = sum_ff + SW'(sq_l_ff) + SW'(sq_r_ff);
      sum_new   = room ? sum_add : sum_ff;
      count_new = room ? count_ff + 1'b1 : count_ff;
      ovf_new   = ovf_ff | ~room;
      dividend  = {sum_new, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (p_valid_ff) begin
         if (p_last_ff) begin
            sum_ff   <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            sum_ff   <= sum_new;
            count_ff <= count_new;
            ovf_ff   <= ovf_new;
         end
      end
   end

   always_comb begin
      trial  = {rem_ff, q_ff[QUOT_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      ge     = trial >= {1'b0, divisor_ff};
      rem_in = ge ? diff[CW-1:0] : trial[CW-1:0];
      q_in   = {q_ff[QUOT_W-2:0], ge};
   end

   always_comb begin
      sx      = {srem_ff, v_ff[RAD_W-1:RAD_W-2]};
      st      = (SREM_W+2)'({root_ff, 2'b01});
      sd      = sx - st;
      sge     = sx >= st;
      srem_in = sge ? sd[SREM_W-1:0] : sx[SREM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff     <= CW'(dividend[DW-1:QUOT_W]);
         q_ff       <= dividend[QUOT_W-1:0];
         divisor_ff <= count_new;
         zero_ff    <= (count_new == '0);
         silent_ff  <= p_silent_ff;
         ovf_res_ff <= ovf_new;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
      if (cmd.root_load) begin
         v_ff    <= RAD_W'(q_ff);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.root_step) begin
         v_ff    <= {v_ff[RAD_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_W-2:0], sge};
         srem_ff <= srem_in;
      end
   end

   always_comb begin
      if (silent_ff || zero_ff) begin
         level = '0;
      end else if (root_ff[ROOT_W-1]) begin
         level = LEVEL_MAX;
      end else begin
         level = root_ff[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            thresh_ff <= csr_wdata;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.out_load) begin
         level_ff   <= level;
         playing_ff <= level > thresh_ff;
         ovf_out_ff <= ovf_res_ff;
      end
   end

   assign stat.pipe_last = p_valid_ff & p_last_ff;
   assign stat.out_busy  = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = level_ff;
   assign rsp_tuser  = {ovf_out_ff, playing_ff};

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_FRAMES))
      else $error("frame count beyond maximum");

   // A new result must never overwrite one that the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten while pending");

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < divisor_ff || zero_ff)
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire

### rtl/stereo_rms_level_detector_top.sv
// Top level of the stereo RMS level detector: controller and datapath.
//
// Each req item is one stereo frame; req_tlast marks the last frame of a
// packet. Frames are taken one per cycle while a packet accumulates. After the
// last frame is taken, intake stops for the result computation: the FLUSH
// state finishes the squares, the one-bit-per-cycle divider runs, a load
// step prepares the two-bit-per-cycle square root, which then runs, and the
// result is written to the rsp output register. Frames beyond MAX_FRAMES
// are dropped and flag overflow in that packet's item. The rsp output
// register holds one result; the next packet is accepted while it waits,
// and only a following result stalls until rsp_tready takes it. Reset
// clears the sums, empties the output and sets the threshold to 655. The
// csr port writes the silence threshold; the user must use it only when
// idle, as the block itself does not enforce this.
`default_nettype none

module stereo_rms_level_detector_top #(
   parameter int unsigned MAX_FRAMES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // left_sample [15:0], right_sample [31:16]
   input  wire logic [2*srld_pkg::SAMPLE_W-1:0] req_tdata,
   // packet_silent [0]
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rms_level [15:0]
   output logic [srld_pkg::LEVEL_W-1:0]         rsp_tdata,
   // audio_playing [0], frames_overflowed [1]
   output logic [1:0]                           rsp_tuser,
   input  wire logic                            csr_wen,
   input  wire logic [srld_pkg::LEVEL_W-1:0]    csr_wdata
);
   import srld_pkg::*;

   srld_cmd_type  cmd;
   srld_stat_type stat;

   srld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   srld_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.in_ready;

endmodule

`default_nettype wire
